@@ sv/gradient_noise_2d_assert.svh @@
`ifndef GRADIENT_NOISE_2D_ASSERT_SVH
`define GRADIENT_NOISE_2D_ASSERT_SVH
// Concurrent assertion macros for the gradient noise block.
// Each use expects i_clk and i_rst_n in scope.

`define GN2_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

`define GN2_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`define GN2_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/gn2_pkg.sv @@
`timescale 1ns / 1ps
// gn2_pkg: shared constants, types and width helpers of the gradient noise block.
// No dependencies.
package gn2_pkg;

    localparam int COORD_W       = 24;
    localparam int CELL_W        = 7;
    localparam int GRAD_BITS     = 14;
    localparam int GRAD_W        = GRAD_BITS + 1;
    localparam int NOISE_W       = 16;
    localparam int NOISE_MAX     = 2 ** (NOISE_W - 1) - 1;
    localparam int NOISE_MIN     = -(2 ** (NOISE_W - 1));

    localparam int GRID_SIZE_DEF = 128;
    localparam int FRAC_BITS_DEF = 8;
    localparam int MID_DEPTH_DEF = 8;
    localparam int OUT_DEPTH_DEF = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef logic signed [GRAD_W-1:0]  t_grad;
    typedef logic signed [NOISE_W-1:0] t_noise;

    function automatic int addr_width(input int grid);
        return $clog2(grid * grid);
    endfunction

    function automatic int mid_width(input int grid, input int frac);
        return 1 + 4 * addr_width(grid) + 2 * frac + 2 * GRAD_W;
    endfunction

endpackage

@@ sv/gradient_noise_2d.sv @@
`timescale 1ns / 1ps
// gradient_noise_2d: top level of the two-dimensional gradient noise block.
// Depends on gn2_pkg, gn2_front, gn2_fifo and gn2_back.
//
// Load items write one gradient pair into a GRID_SIZE x GRID_SIZE wrapping grid; evaluate
// items return one saturated noise sample each, loads return nothing. Load every grid cell
// that an evaluate touches before evaluating: the store has no reset. One item is taken
// per cycle unless full, loads and evaluates in any order, and a result reaches the output
// queue after the front, mid queue and back stages. The rate is set by the gradient store,
// held in four copies so that all four corners of a point are read in the same cycle.
module gradient_noise_2d
    import gn2_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_command,
    input  logic [COORD_W-1:0] i_x_coord,
    input  logic [COORD_W-1:0] i_y_coord,
    input  logic [CELL_W-1:0]  i_cell_row,
    input  logic [CELL_W-1:0]  i_cell_col,
    input  t_grad              i_grad_x_value,
    input  t_grad              i_grad_y_value,
    output logic               empty,
    input  logic               pop,
    output t_noise             o_noise_value
);

    localparam int MID_W = mid_width(GRID_SIZE, FRAC_BITS);

    logic               mid_push;
    logic [MID_W-1:0]   mid_wdata;
    logic               mid_pop;
    logic               mid_empty;
    logic [MID_W-1:0]   mid_rdata;
    logic               out_push;
    t_noise             out_wdata;
    logic               out_pop;
    logic [NOISE_W-1:0] out_rdata;

    assign out_pop       = pop && !empty;
    assign o_noise_value = t_noise'(out_rdata);

    gn2_front #(
        .GRID_SIZE (GRID_SIZE),
        .FRAC_BITS (FRAC_BITS),
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_command      (i_command),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_grad_x_value (i_grad_x_value),
        .i_grad_y_value (i_grad_y_value),
        .i_mid_pop      (mid_pop),
        .o_mid_push     (mid_push),
        .o_mid_data     (mid_wdata)
    );

    gn2_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_wdata),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_rdata)
    );

    gn2_back #(
        .GRID_SIZE (GRID_SIZE),
        .FRAC_BITS (FRAC_BITS),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_mid_data  (mid_rdata),
        .o_mid_pop   (mid_pop),
        .i_out_pop   (out_pop),
        .o_out_push  (out_push),
        .o_out_data  (out_wdata)
    );

    gn2_fifo #(
        .WIDTH (NOISE_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_wdata),
        .i_pop   (out_pop),
        .o_empty (empty),
        .o_data  (out_rdata)
    );

endmodule

@@ sv/gn2_fifo.sv @@
`timescale 1ns / 1ps
`include "gradient_noise_2d_assert.svh"
// gn2_fifo: small register queue with combinational head read.
// Depends on gn2_pkg for defaults.
module gn2_fifo
    import gn2_pkg::*;
#(
    parameter int WIDTH = NOISE_W,
    parameter int DEPTH = OUT_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CNTW-1:0]  r_count;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic [CNTW-1:0]  n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count + CNTW'(i_push) - CNTW'(i_pop);
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    `GN2_ASSERT_NEVER(a_fifo_overflow, i_push && r_count == CNTW'(DEPTH), "queue overflow")
    `GN2_ASSERT_IMPLY(a_fifo_underflow, i_pop, r_count != '0, "pop from empty queue")

endmodule

@@ sv/gn2_front.sv @@
`timescale 1ns / 1ps
`include "gradient_noise_2d_assert.svh"
// gn2_front: accepts items, splits coordinates, wraps cell indices by the grid size
// and forms the four corner addresses. Depends on gn2_pkg.
module gn2_front
    import gn2_pkg::*;
#(
    parameter int GRID_SIZE  = GRID_SIZE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int MID_DEPTH  = MID_DEPTH_DEF,
    localparam int MID_W     = mid_width(GRID_SIZE, FRAC_BITS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_command,
    input  logic [COORD_W-1:0] i_x_coord,
    input  logic [COORD_W-1:0] i_y_coord,
    input  logic [CELL_W-1:0]  i_cell_row,
    input  logic [CELL_W-1:0]  i_cell_col,
    input  t_grad              i_grad_x_value,
    input  t_grad              i_grad_y_value,
    input  logic               i_mid_pop,
    output logic               o_mid_push,
    output logic [MID_W-1:0]   o_mid_data
);

    localparam int CW  = COORD_W - FRAC_BITS;
    localparam int IW  = $clog2(GRID_SIZE);
    localparam int AW  = addr_width(GRID_SIZE);
    localparam int SH  = CW + IW + 1;
    localparam int RW  = CW + 3;
    localparam int PXW = CW + RW;
    localparam int QGW = CW + IW + 1;
    localparam int RCW = $clog2(MID_DEPTH + 1);
    localparam longint RECIP_L = ((longint'(1) << SH) / longint'(GRID_SIZE)) + longint'(1);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

    logic               r_s0_vld, r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic               r_s0_op, r_s1_op, r_s2_op, r_s3_op, r_s4_op;
    logic [CW-1:0]      r_s0_vx, r_s0_vy, r_s1_vx, r_s1_vy, r_s2_vx, r_s2_vy;
    logic [PXW-1:0]     r_s1_px, r_s1_py;
    logic [CW-1:0]      r_s2_qgx, r_s2_qgy;
    logic [IW-1:0]      r_s3_rx, r_s3_rx1, r_s3_ry, r_s3_ry1;
    logic [AW-1:0]      r_s4_a00, r_s4_a10, r_s4_a01, r_s4_a11;
    logic [FRAC_BITS-1:0] r_s0_fx, r_s0_fy, r_s1_fx, r_s1_fy, r_s2_fx, r_s2_fy;
    logic [FRAC_BITS-1:0] r_s3_fx, r_s3_fy, r_s4_fx, r_s4_fy;
    t_grad              r_s0_gx, r_s0_gy, r_s1_gx, r_s1_gy, r_s2_gx, r_s2_gy;
    t_grad              r_s3_gx, r_s3_gy, r_s4_gx, r_s4_gy;
    logic [RCW-1:0]     r_mid_resv;
    logic [RCW-1:0]     n_mid_resv;

    logic               accept;
    logic [CW-1:0]      q_x, q_y;
    logic [QGW-1:0]     qg_x, qg_y;
    logic [CW-1:0]      diff_x, diff_y;
    logic [IW-1:0]      rem_x, rem_y;
    logic [AW-1:0]      base_y0, base_y1;

    assign o_full = (r_mid_resv == RCW'(MID_DEPTH));
    assign accept = i_push && !o_full;

    assign n_mid_resv = r_mid_resv + RCW'(accept) - RCW'(i_mid_pop);

    assign q_x  = CW'(r_s1_px >> SH);
    assign q_y  = CW'(r_s1_py >> SH);
    assign qg_x = QGW'(q_x) * QGW'(GRID_SIZE);
    assign qg_y = QGW'(q_y) * QGW'(GRID_SIZE);

    assign diff_x = r_s2_vx - r_s2_qgx;
    assign diff_y = r_s2_vy - r_s2_qgy;
    assign rem_x  = IW'(diff_x);
    assign rem_y  = IW'(diff_y);

    assign base_y0 = AW'(AW'(r_s3_ry) * AW'(GRID_SIZE));
    assign base_y1 = AW'(AW'(r_s3_ry1) * AW'(GRID_SIZE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld   <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_s4_vld   <= 1'b0;
            r_mid_resv <= '0;
        end else begin
            r_s0_vld   <= accept;
            r_s1_vld   <= r_s0_vld;
            r_s2_vld   <= r_s1_vld;
            r_s3_vld   <= r_s2_vld;
            r_s4_vld   <= r_s3_vld;
            r_mid_resv <= n_mid_resv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_op <= i_command;
        if (i_command == CMD_EVAL) begin
            r_s0_vx <= i_x_coord[COORD_W-1:FRAC_BITS];
            r_s0_vy <= i_y_coord[COORD_W-1:FRAC_BITS];
        end else begin
            r_s0_vx <= CW'(i_cell_col);
            r_s0_vy <= CW'(i_cell_row);
        end
        r_s0_fx <= i_x_coord[FRAC_BITS-1:0];
        r_s0_fy <= i_y_coord[FRAC_BITS-1:0];
        r_s0_gx <= i_grad_x_value;
        r_s0_gy <= i_grad_y_value;

        r_s1_op <= r_s0_op;
        r_s1_px <= PXW'(r_s0_vx) * PXW'(RECIP);
        r_s1_py <= PXW'(r_s0_vy) * PXW'(RECIP);
        r_s1_vx <= r_s0_vx;
        r_s1_vy <= r_s0_vy;
        r_s1_fx <= r_s0_fx;
        r_s1_fy <= r_s0_fy;
        r_s1_gx <= r_s0_gx;
        r_s1_gy <= r_s0_gy;

        r_s2_op  <= r_s1_op;
        r_s2_qgx <= CW'(qg_x);
        r_s2_qgy <= CW'(qg_y);
        r_s2_vx  <= r_s1_vx;
        r_s2_vy  <= r_s1_vy;
        r_s2_fx  <= r_s1_fx;
        r_s2_fy  <= r_s1_fy;
        r_s2_gx  <= r_s1_gx;
        r_s2_gy  <= r_s1_gy;

        r_s3_op  <= r_s2_op;
        r_s3_rx  <= rem_x;
        r_s3_ry  <= rem_y;
        r_s3_rx1 <= (rem_x == IW'(GRID_SIZE - 1)) ? '0 : rem_x + 1'b1;
        r_s3_ry1 <= (rem_y == IW'(GRID_SIZE - 1)) ? '0 : rem_y + 1'b1;
        r_s3_fx  <= r_s2_fx;
        r_s3_fy  <= r_s2_fy;
        r_s3_gx  <= r_s2_gx;
        r_s3_gy  <= r_s2_gy;

        r_s4_op  <= r_s3_op;
        r_s4_a00 <= base_y0 + AW'(r_s3_rx);
        r_s4_a10 <= base_y0 + AW'(r_s3_rx1);
        r_s4_a01 <= base_y1 + AW'(r_s3_rx);
        r_s4_a11 <= base_y1 + AW'(r_s3_rx1);
        r_s4_fx  <= r_s3_fx;
        r_s4_fy  <= r_s3_fy;
        r_s4_gx  <= r_s3_gx;
        r_s4_gy  <= r_s3_gy;
    end

    assign o_mid_push = r_s4_vld;
    assign o_mid_data = {r_s4_op, r_s4_a00, r_s4_a10, r_s4_a01, r_s4_a11,
                         r_s4_fx, r_s4_fy, r_s4_gx, r_s4_gy};

    `GN2_ASSERT_ALWAYS(a_mid_resv_bound, r_mid_resv <= RCW'(MID_DEPTH), "mid queue overbooked")
    `GN2_ASSERT_IMPLY(a_cell_wrap, r_s2_vld, (int'(diff_x) < GRID_SIZE) && (int'(diff_y) < GRID_SIZE), "cell index not reduced")

endmodule

@@ sv/gn2_back.sv @@
`timescale 1ns / 1ps
`include "gradient_noise_2d_assert.svh"
// gn2_back: gradient store, corner dot products, two-axis linear blend and saturation.
// Depends on gn2_pkg.
module gn2_back
    import gn2_pkg::*;
#(
    parameter int GRID_SIZE  = GRID_SIZE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int OUT_DEPTH  = OUT_DEPTH_DEF,
    localparam int MID_W     = mid_width(GRID_SIZE, FRAC_BITS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mid_empty,
    input  logic [MID_W-1:0] i_mid_data,
    output logic             o_mid_pop,
    input  logic             i_out_pop,
    output logic             o_out_push,
    output t_noise           o_out_data
);

    localparam int AW    = addr_width(GRID_SIZE);
    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int EW    = 2 * GRAD_W;
    localparam int PW    = FRAC_BITS + 1 + GRAD_W;
    localparam int DW    = FRAC_BITS + GRAD_W + 2;
    localparam int WW    = FRAC_BITS + 2;
    localparam int LW    = DW + FRAC_BITS + 1;
    localparam int OCW   = $clog2(OUT_DEPTH + 1);
    localparam logic [3:0] HI_X = 4'b1010;
    localparam logic [3:0] HI_Y = 4'b1100;
    localparam logic signed [LW-1:0] HALF_L = LW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DW-1:0] HALF_D = DW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DW-1:0] SAT_HI = DW'(NOISE_MAX);
    localparam logic signed [DW-1:0] SAT_LO = DW'(NOISE_MIN);

    logic                 mid_op;
    logic [AW-1:0]        mid_a00, mid_a10, mid_a01, mid_a11;
    logic [FRAC_BITS-1:0] mid_fx, mid_fy;
    t_grad                mid_gx, mid_gy;
    logic                 issue;

    logic [OCW-1:0]       r_out_resv;
    logic [OCW-1:0]       n_out_resv;

    logic                 r_b0_vld, r_b0_op;
    logic [AW-1:0]        r_b0_addr [4];
    logic [FRAC_BITS-1:0] r_b0_fx, r_b0_fy;
    t_grad                r_b0_gx, r_b0_gy;

    logic                 r_b1_ev, r_b2_ev, r_b3_ev, r_b4_ev, r_b5_ev, r_b6_ev, r_b7_ev;
    logic [FRAC_BITS-1:0] r_b1_fx, r_b1_fy, r_b2_fx, r_b2_fy, r_b3_fx, r_b3_fy;
    logic [FRAC_BITS-1:0] r_b4_fy, r_b5_fy;
    logic [EW-1:0]        rd_data [4];

    logic signed [PW-1:0] r_b2_px [4];
    logic signed [PW-1:0] r_b2_py [4];
    logic signed [DW-1:0] r_b3_n [4];
    logic signed [LW-1:0] r_b4_m [4];
    logic signed [DW-1:0] r_b5_r [2];
    logic signed [LW-1:0] r_b6_m [2];
    logic signed [DW-1:0] r_b7_t;

    logic signed [FRAC_BITS:0] dx [4];
    logic signed [FRAC_BITS:0] dy [4];
    t_grad                     gx [4];
    t_grad                     gy [4];
    logic signed [WW-1:0]      wcx, wx, wcy, wy;
    logic signed [LW-1:0]      sum_r0, sum_r1, sum_y;
    logic signed [DW-1:0]      fin_t, fin_v;

    assign {mid_op, mid_a00, mid_a10, mid_a01, mid_a11,
            mid_fx, mid_fy, mid_gx, mid_gy} = i_mid_data;

    assign issue = !i_mid_empty && (mid_op == CMD_LOAD || r_out_resv != OCW'(OUT_DEPTH));
    assign o_mid_pop = issue;
    assign n_out_resv = r_out_resv + OCW'(issue && mid_op == CMD_EVAL) - OCW'(i_out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_resv <= '0;
            r_b0_vld   <= 1'b0;
            r_b1_ev    <= 1'b0;
            r_b2_ev    <= 1'b0;
            r_b3_ev    <= 1'b0;
            r_b4_ev    <= 1'b0;
            r_b5_ev    <= 1'b0;
            r_b6_ev    <= 1'b0;
            r_b7_ev    <= 1'b0;
        end else begin
            r_out_resv <= n_out_resv;
            r_b0_vld   <= issue;
            r_b1_ev    <= r_b0_vld && r_b0_op == CMD_EVAL;
            r_b2_ev    <= r_b1_ev;
            r_b3_ev    <= r_b2_ev;
            r_b4_ev    <= r_b3_ev;
            r_b5_ev    <= r_b4_ev;
            r_b6_ev    <= r_b5_ev;
            r_b7_ev    <= r_b6_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0_op      <= mid_op;
        r_b0_addr[0] <= mid_a00;
        r_b0_addr[1] <= mid_a10;
        r_b0_addr[2] <= mid_a01;
        r_b0_addr[3] <= mid_a11;
        r_b0_fx      <= mid_fx;
        r_b0_fy      <= mid_fy;
        r_b0_gx      <= mid_gx;
        r_b0_gy      <= mid_gy;
    end

    // one copy of the store per corner: every load writes all four
    for (genvar k = 0; k < 4; k++) begin : g_copy
        logic [EW-1:0] r_mem [CELLS];
        logic [EW-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (r_b0_vld && r_b0_op == CMD_LOAD) begin
                r_mem[r_b0_addr[0]] <= {r_b0_gx, r_b0_gy};
            end
            r_rd <= r_mem[r_b0_addr[k]];
        end

        assign rd_data[k] = r_rd;
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            dx[k] = $signed({HI_X[k], r_b1_fx});
            dy[k] = $signed({HI_Y[k], r_b1_fy});
            gx[k] = t_grad'(rd_data[k][EW-1:GRAD_W]);
            gy[k] = t_grad'(rd_data[k][GRAD_W-1:0]);
        end
    end

    assign wcx = $signed({1'b0, {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, r_b3_fx}});
    assign wx  = $signed({2'b00, r_b3_fx});
    assign wcy = $signed({1'b0, {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, r_b5_fy}});
    assign wy  = $signed({2'b00, r_b5_fy});

    assign sum_r0 = r_b4_m[0] + r_b4_m[1] + HALF_L;
    assign sum_r1 = r_b4_m[2] + r_b4_m[3] + HALF_L;
    assign sum_y  = r_b6_m[0] + r_b6_m[1] + HALF_L;

    always_ff @(posedge i_clk) begin
        r_b1_fx <= r_b0_fx;
        r_b1_fy <= r_b0_fy;

        for (int k = 0; k < 4; k++) begin
            r_b2_px[k] <= PW'(dx[k]) * PW'(gx[k]);
            r_b2_py[k] <= PW'(dy[k]) * PW'(gy[k]);
            r_b3_n[k]  <= DW'(r_b2_px[k]) + DW'(r_b2_py[k]);
        end
        r_b2_fx <= r_b1_fx;
        r_b2_fy <= r_b1_fy;
        r_b3_fx <= r_b2_fx;
        r_b3_fy <= r_b2_fy;

        r_b4_m[0] <= LW'(r_b3_n[0]) * LW'(wcx);
        r_b4_m[1] <= LW'(r_b3_n[1]) * LW'(wx);
        r_b4_m[2] <= LW'(r_b3_n[2]) * LW'(wcx);
        r_b4_m[3] <= LW'(r_b3_n[3]) * LW'(wx);
        r_b4_fy   <= r_b3_fy;

        r_b5_r[0] <= DW'(sum_r0 >>> FRAC_BITS);
        r_b5_r[1] <= DW'(sum_r1 >>> FRAC_BITS);
        r_b5_fy   <= r_b4_fy;

        r_b6_m[0] <= LW'(r_b5_r[0]) * LW'(wcy);
        r_b6_m[1] <= LW'(r_b5_r[1]) * LW'(wy);

        r_b7_t <= DW'(sum_y >>> FRAC_BITS);
    end

    assign fin_t = r_b7_t + HALF_D;
    assign fin_v = fin_t >>> FRAC_BITS;

    always_comb begin
        if (fin_v > SAT_HI) begin
            o_out_data = t_noise'(NOISE_MAX);
        end else if (fin_v < SAT_LO) begin
            o_out_data = t_noise'(NOISE_MIN);
        end else begin
            o_out_data = t_noise'(fin_v[NOISE_W-1:0]);
        end
    end

    assign o_out_push = r_b7_ev;

    `GN2_ASSERT_ALWAYS(a_out_resv_bound, r_out_resv <= OCW'(OUT_DEPTH), "result queue overbooked")

endmodule

@@ test/gn2_noise_checker.sv @@
`timescale 1ns / 1ps
// gn2_noise_checker: watches both queue sides of gradient_noise_2d, predicts each noise
// sample from its own copy of the gradient grid and compares in transfer order.
// Depends on gn2_pkg.
module gn2_noise_checker
    import gn2_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic               i_command,
    input  logic [COORD_W-1:0] i_x_coord,
    input  logic [COORD_W-1:0] i_y_coord,
    input  logic [CELL_W-1:0]  i_cell_row,
    input  logic [CELL_W-1:0]  i_cell_col,
    input  t_grad              i_grad_x_value,
    input  t_grad              i_grad_y_value,
    input  logic               i_empty,
    input  logic               i_pop,
    input  t_noise             i_noise_value,
    output int                 o_mismatch_count,
    output int                 o_pending_count,
    output int                 o_compared_count
);

    localparam int     GRID_CELLS = GRID_SIZE_DEF * GRID_SIZE_DEF;
    localparam longint FRAC_ONE   = longint'(1) << FRAC_BITS_DEF;

    int     grad_x_copy [GRID_CELLS];
    int     grad_y_copy [GRID_CELLS];
    t_noise pending_noise [$];
    int     mismatch_count;
    int     compared_count;
    int     pending_count;

    assign o_mismatch_count = mismatch_count;
    assign o_pending_count  = pending_count;
    assign o_compared_count = compared_count;

    task automatic report_mismatch(input string what);
        $display("[gn2 check] %0t ns: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic longint corner_dot(input logic [CELL_W-1:0] row,
                                          input logic [CELL_W-1:0] col,
                                          input longint dx, input longint dy);
        return dx * grad_x_copy[{row, col}] + dy * grad_y_copy[{row, col}];
    endfunction

    // round half up, then floor
    function automatic longint round_frac(input longint v);
        return (v + FRAC_ONE / 2) >>> FRAC_BITS_DEF;
    endfunction

    function automatic longint lerp_frac(input longint a, input longint b, input longint w);
        return round_frac(a * (FRAC_ONE - w) + b * w);
    endfunction

    // grid is 2**CELL_W wide, so corner indices wrap in CELL_W bits
    function automatic t_noise predict_noise(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
        longint            fx;
        longint            fy;
        longint            r0;
        longint            r1;
        longint            v;
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic [CELL_W-1:0] cx1;
        logic [CELL_W-1:0] cy1;
        fx  = longint'(x[FRAC_BITS_DEF-1:0]);
        fy  = longint'(y[FRAC_BITS_DEF-1:0]);
        cx  = CELL_W'(x >> FRAC_BITS_DEF);
        cy  = CELL_W'(y >> FRAC_BITS_DEF);
        cx1 = CELL_W'(cx + 1);
        cy1 = CELL_W'(cy + 1);
        r0  = lerp_frac(corner_dot(cy, cx, fx, fy),
                        corner_dot(cy, cx1, fx - FRAC_ONE, fy), fx);
        r1  = lerp_frac(corner_dot(cy1, cx, fx, fy - FRAC_ONE),
                        corner_dot(cy1, cx1, fx - FRAC_ONE, fy - FRAC_ONE), fx);
        v   = round_frac(lerp_frac(r0, r1, fy));
        if (v > NOISE_MAX) begin
            v = NOISE_MAX;
        end else if (v < NOISE_MIN) begin
            v = NOISE_MIN;
        end
        return t_noise'(v);
    endfunction

    always @(posedge i_clk) begin : watch
        t_noise want;
        if (i_rst_n) begin
            if (i_push && !i_full) begin
                if (i_command == CMD_LOAD) begin
                    grad_x_copy[{i_cell_row, i_cell_col}] = int'(i_grad_x_value);
                    grad_y_copy[{i_cell_row, i_cell_col}] = int'(i_grad_y_value);
                end else begin
                    pending_noise.push_back(predict_noise(i_x_coord, i_y_coord));
                end
            end
            if (i_pop && !i_empty) begin
                if (pending_noise.size() == 0) begin
                    report_mismatch($sformatf("noise %0d transferred with nothing pending",
                                              i_noise_value));
                end else begin
                    want = pending_noise.pop_front();
                    compared_count++;
                    if (i_noise_value !== want) begin
                        report_mismatch($sformatf("noise sample %0d: got %0d, want %0d",
                                                  compared_count, i_noise_value, want));
                    end
                end
            end
            pending_count = pending_noise.size();
        end
    end

endmodule

@@ test/tb_gradient_noise_2d.sv @@
`timescale 1ns / 1ps
// tb_gradient_noise_2d: drives grid loads and noise evaluates into gradient_noise_2d under
// changing idle mixes and one long output stall; gn2_noise_checker scores the results.
// Depends on gn2_pkg, gradient_noise_2d and gn2_noise_checker.
module tb_gradient_noise_2d;
    import gn2_pkg::*;

    localparam int    CLK_HALF_NS     = 6;
    localparam int    RESET_CYCLES    = 12;
    localparam int    ITEM_TARGET     = 1750;
    localparam int    OUT_HOLD_CYCLES = 400;
    localparam int    DRAIN_CYCLES    = 40;
    localparam int    TIMEOUT_NS      = 5_000_000;
    localparam int    GRID_CELLS      = GRID_SIZE_DEF * GRID_SIZE_DEF;
    localparam int    WORK_BASE       = GRID_SIZE_DEF - 4;
    localparam int    WORK_SPAN       = 12;
    localparam t_grad GRAD_TOP        = t_grad'(2 ** (GRAD_W - 1) - 1);
    localparam t_grad GRAD_BOTTOM     = t_grad'(-(2 ** (GRAD_W - 1)));

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic               i_command;
    logic [COORD_W-1:0] i_x_coord;
    logic [COORD_W-1:0] i_y_coord;
    logic [CELL_W-1:0]  i_cell_row;
    logic [CELL_W-1:0]  i_cell_col;
    t_grad              i_grad_x_value;
    t_grad              i_grad_y_value;
    logic               empty;
    logic               pop;
    t_noise             o_noise_value;

    int mismatch_count;
    int pending_count;
    int compared_count;
    int load_count;
    int eval_count;
    int tx_idle_pct;
    int rx_idle_pct;
    bit drain_hold;
    bit cell_loaded [GRID_CELLS];

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    gradient_noise_2d DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_grad_x_value (i_grad_x_value),
        .i_grad_y_value (i_grad_y_value),
        .empty          (empty),
        .pop            (pop),
        .o_noise_value  (o_noise_value)
    );

    gn2_noise_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_command        (i_command),
        .i_x_coord        (i_x_coord),
        .i_y_coord        (i_y_coord),
        .i_cell_row       (i_cell_row),
        .i_cell_col       (i_cell_col),
        .i_grad_x_value   (i_grad_x_value),
        .i_grad_y_value   (i_grad_y_value),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_noise_value    (o_noise_value),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count),
        .o_compared_count (compared_count)
    );

    function automatic t_grad random_grad();
        case ($urandom_range(7))
            0: return GRAD_TOP;
            1: return GRAD_BOTTOM;
            2: return '0;
            default: return t_grad'($urandom);
        endcase
    endfunction

    // cell index near the grid edge so wrap is hit often; upper bits are free
    function automatic logic [COORD_W-1:0] work_coord();
        logic [CELL_W-1:0]        cell_idx;
        logic [FRAC_BITS_DEF-1:0] frac;
        cell_idx = CELL_W'(WORK_BASE + $urandom_range(WORK_SPAN - 1));
        case ($urandom_range(4))
            0: frac = '0;
            1: frac = '1;
            default: frac = FRAC_BITS_DEF'($urandom);
        endcase
        return COORD_W'({$urandom, cell_idx, frac});
    endfunction

    task automatic push_item(input logic cmd, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [CELL_W-1:0] row,
                             input logic [CELL_W-1:0] col, input t_grad gx, input t_grad gy);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_command      <= cmd;
        i_x_coord      <= x;
        i_y_coord      <= y;
        i_cell_row     <= row;
        i_cell_col     <= col;
        i_grad_x_value <= gx;
        i_grad_y_value <= gy;
        do @(posedge i_clk); while (full);
        if (cmd == CMD_LOAD) begin
            load_count++;
        end else begin
            eval_count++;
        end
    endtask

    task automatic load_cell(input logic [CELL_W-1:0] row, input logic [CELL_W-1:0] col,
                             input t_grad gx, input t_grad gy);
        push_item(CMD_LOAD, COORD_W'($urandom), COORD_W'($urandom), row, col, gx, gy);
        cell_loaded[{row, col}] = 1'b1;
    endtask

    // load any missing corner first so no unwritten cell is ever read
    task automatic eval_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        logic [CELL_W-1:0] col0;
        logic [CELL_W-1:0] row0;
        logic [CELL_W-1:0] row;
        logic [CELL_W-1:0] col;
        col0 = CELL_W'(x >> FRAC_BITS_DEF);
        row0 = CELL_W'(y >> FRAC_BITS_DEF);
        for (int dr = 0; dr < 2; dr++) begin
            for (int dc = 0; dc < 2; dc++) begin
                row = CELL_W'(row0 + dr);
                col = CELL_W'(col0 + dc);
                if (!cell_loaded[{row, col}]) begin
                    load_cell(row, col, random_grad(), random_grad());
                end
            end
        end
        push_item(CMD_EVAL, x, y, CELL_W'($urandom), CELL_W'($urandom),
                  random_grad(), random_grad());
    endtask

    initial begin : receiver
        bit hold_served;
        hold_served = 1'b0;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (drain_hold && !hold_served) begin
                hold_served = 1'b1;
                pop <= 1'b0;
                repeat (OUT_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : stimulus
        int phase;
        int sel;
        int items;
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        i_command      <= CMD_LOAD;
        i_x_coord      <= '0;
        i_y_coord      <= '0;
        i_cell_row     <= '0;
        i_cell_col     <= '0;
        i_grad_x_value <= '0;
        i_grad_y_value <= '0;
        drain_hold     <= 1'b0;
        rx_idle_pct    <= 53;
        tx_idle_pct    = 12;
        phase          = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // gradients pointing toward the cell center, then edge fractions
        load_cell(7'd0, 7'd0, GRAD_TOP, GRAD_TOP);
        load_cell(7'd0, 7'd1, GRAD_BOTTOM, GRAD_TOP);
        load_cell(7'd1, 7'd0, GRAD_TOP, GRAD_BOTTOM);
        load_cell(7'd1, 7'd1, GRAD_BOTTOM, GRAD_BOTTOM);
        eval_at(24'h000000, 24'h000000);
        eval_at(24'h000080, 24'h000080);
        eval_at(24'h0000FF, 24'h0000FF);
        eval_at(24'h0000FF, 24'h000000);
        eval_at(24'h000001, 24'h0000FF);
        load_cell(7'd0, 7'd0, '0, '0);
        eval_at(24'h000080, 24'h000080);
        // grid wrap at both edges and the largest coordinates
        load_cell(7'd127, 7'd127, GRAD_BOTTOM, GRAD_TOP);
        load_cell(7'd127, 7'd0, GRAD_TOP, GRAD_TOP);
        load_cell(7'd0, 7'd127, GRAD_BOTTOM, GRAD_BOTTOM);
        eval_at(24'h007F80, 24'h007F80);
        eval_at(24'hFFFFFF, 24'hFFFFFF);
        eval_at(24'hFFFFFF, 24'h000000);
        eval_at(24'h800000, 24'h7FFF7F);

        while (load_count + eval_count < ITEM_TARGET) begin
            items = load_count + eval_count;
            if (phase == 1 && items >= ITEM_TARGET / 3) begin
                phase       = 2;
                tx_idle_pct = 53;
                rx_idle_pct <= 12;
            end else if (phase == 2 && items >= 2 * ITEM_TARGET / 3) begin
                phase       = 3;
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                drain_hold  <= 1'b1;
            end
            sel = $urandom_range(99);
            if (sel < 65) begin
                eval_at(work_coord(), work_coord());
            end else if (sel < 75) begin
                eval_at(COORD_W'($urandom), COORD_W'($urandom));
            end else if (sel < 90) begin
                load_cell(CELL_W'(WORK_BASE + $urandom_range(WORK_SPAN - 1)),
                          CELL_W'(WORK_BASE + $urandom_range(WORK_SPAN - 1)),
                          random_grad(), random_grad());
            end else begin
                load_cell(CELL_W'($urandom), CELL_W'($urandom), random_grad(), random_grad());
            end
        end
        push <= 1'b0;

        @(posedge i_clk);
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d grid loads and %0d evaluates transferred, %0d noise samples checked",
                 load_count, eval_count, compared_count);
        $display("tb: idle mixes 12/53, 53/12 and 0/0 percent, one %0d-cycle output stall",
                 OUT_HOLD_CYCLES);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("tb_gradient_noise_2d passed");
        end else begin
            $display("tb_gradient_noise_2d failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: timeout with %0d samples still pending", pending_count);
        $display("tb_gradient_noise_2d failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/gn2_pkg.sv
sv/gn2_fifo.sv
sv/gn2_front.sv
sv/gn2_back.sv
sv/gradient_noise_2d.sv
test/gn2_noise_checker.sv
test/tb_gradient_noise_2d.sv
